>>> rtl/pbm_pkg.sv
// pbm_pkg: shared constants and types of the pixel blend mix unit
package pbm_pkg;

  localparam int PBM_FRAC_BITS = 16;

  localparam logic [1:0] KIND_SCALAR = 2'd0;
  localparam logic [1:0] KIND_VECTOR = 2'd1;
  localparam logic [1:0] KIND_COLOR  = 2'd2;

  localparam logic [1:0] REG_KIND  = 2'd0;
  localparam logic [1:0] REG_MODE  = 2'd1;
  localparam logic [1:0] REG_LANE  = 2'd2;
  localparam logic [1:0] REG_CLAMP = 2'd3;

  localparam logic [4:0] MODE_MIX        = 5'd0;
  localparam logic [4:0] MODE_DARKEN     = 5'd1;
  localparam logic [4:0] MODE_MULTIPLY   = 5'd2;
  localparam logic [4:0] MODE_BURN       = 5'd3;
  localparam logic [4:0] MODE_LIGHTEN    = 5'd4;
  localparam logic [4:0] MODE_SCREEN     = 5'd5;
  localparam logic [4:0] MODE_DODGE      = 5'd6;
  localparam logic [4:0] MODE_OVERLAY    = 5'd7;
  localparam logic [4:0] MODE_ADD        = 5'd8;
  localparam logic [4:0] MODE_SOFTLIGHT  = 5'd9;
  localparam logic [4:0] MODE_LINEAR     = 5'd10;
  localparam logic [4:0] MODE_DIFFERENCE = 5'd11;
  localparam logic [4:0] MODE_EXCLUSION  = 5'd12;
  localparam logic [4:0] MODE_SUBTRACT   = 5'd13;
  localparam logic [4:0] MODE_DIVIDE     = 5'd14;

  typedef struct packed {
    logic [1:0] data_kind;
    logic [4:0] blend_mode;
    logic       per_lane_factor;
    logic       clamp_enable;
  } pbm_cfg_t;

  typedef struct packed {
    logic signed [31:0] f;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } pbm_raw_t;

endpackage

>>> rtl/pbm_div.sv
// pbm_div: pipelined restoring divider, one quotient bit per stage, with side data
module pbm_div #(
  parameter int NUM_W  = 33,
  parameter int DEN_W  = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  logic              v   [NUM_W];
  logic [DEN_W-1:0]  rem [NUM_W];
  logic [NUM_W-1:0]  nr  [NUM_W];
  logic [NUM_W-1:0]  q   [NUM_W];
  logic [DEN_W-1:0]  d   [NUM_W];
  logic [SIDE_W-1:0] s   [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              vi;
    logic [DEN_W-1:0]  ri;
    logic [DEN_W-1:0]  di;
    logic [NUM_W-1:0]  ni;
    logic [NUM_W-1:0]  qi;
    logic [SIDE_W-1:0] si;
    logic [DEN_W:0]    trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign ri = '0;
      assign ni = num;
      assign qi = '0;
      assign di = den;
      assign si = side_in;
    end else begin : g_next
      assign vi = v[k-1];
      assign ri = rem[k-1];
      assign ni = nr[k-1];
      assign qi = q[k-1];
      assign di = d[k-1];
      assign si = s[k-1];
    end

    assign trial = {ri, ni[NUM_W-1]};
    assign ge    = trial >= {1'b0, di};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? DEN_W'(trial - {1'b0, di}) : trial[DEN_W-1:0];
        nr[k]  <= ni << 1;
        q[k]   <= {qi[NUM_W-2:0], ge};
        d[k]   <= di;
        s[k]   <= si;
      end
    end
  end

  assign out_valid = v[NUM_W-1];
  assign quo       = q[NUM_W-1];
  assign side_out  = s[NUM_W-1];

endmodule

>>> rtl/pixel_blend_mix_unit.sv
// pixel_blend_mix_unit: three-lane lerp and color blend pipeline
//
//   channel | handshake              | word
//   input   | in_valid / in_stall    | fac_x..z, a_x..z, b_x..z
//   output  | out_valid / out_stall  | out_x, out_y, out_z
//   config  | apb psel/penable/pready| data_kind, blend_mode, per_lane_factor, clamp_enable
//
// one word per cycle while the output word is not stalled
// the restoring divider computes one quotient bit per stage on each lane
// synchronous reset clears valid bits and configuration registers; no clearing pass
// a stalled output word freezes the whole pipeline and stalls the input
module pixel_blend_mix_unit import pbm_pkg::*; #(
  parameter int FRAC_BITS = PBM_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] fac_x,
  input  logic signed [31:0] fac_y,
  input  logic signed [31:0] fac_z,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW    = FRAC_BITS + 1;
  localparam int SW    = CW + 2;
  localparam int RW    = CW + 3;
  localparam int NW    = 2 * FRAC_BITS + 1;
  localparam int SIDEW = RW + 2 * CW + 96;

  localparam logic [CW-1:0]        ONE_C  = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0]        HALF_C = CW'(1) << (FRAC_BITS - 1);
  localparam logic signed [31:0]   ONE_S  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [65:0]   MAX_W  = 66'sd2147483647;
  localparam logic signed [65:0]   MIN_W  = -66'sd2147483648;

  function automatic logic [CW-1:0] clip_c(input logic signed [31:0] x);
    if (x < 0) begin
      clip_c = '0;
    end else if (x > ONE_S) begin
      clip_c = ONE_C;
    end else begin
      clip_c = x[CW-1:0];
    end
  endfunction

  function automatic logic signed [31:0] clip_s(input logic signed [31:0] x);
    if (x < 0) begin
      clip_s = '0;
    end else if (x > ONE_S) begin
      clip_s = ONE_S;
    end else begin
      clip_s = x;
    end
  endfunction

  pbm_cfg_t cfg;
  logic     en;
  logic     v1, v2, v3, v4, v5, va, vb, vc;
  logic [2:0] dv;
  pbm_raw_t raw_in [3];
  logic signed [31:0] f_d [3];
  logic signed [31:0] res [3];

  assign pready   = 1'b1;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_KIND:  cfg.data_kind       <= pwdata[1:0];
        REG_MODE:  cfg.blend_mode      <= pwdata[4:0];
        REG_LANE:  cfg.per_lane_factor <= pwdata[0];
        REG_CLAMP: cfg.clamp_enable    <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_KIND:  prdata = {30'b0, cfg.data_kind};
      REG_MODE:  prdata = {27'b0, cfg.blend_mode};
      REG_LANE:  prdata = {31'b0, cfg.per_lane_factor};
      REG_CLAMP: prdata = {31'b0, cfg.clamp_enable};
    endcase
  end

  assign raw_in[0] = '{f: fac_x, a: a_x, b: b_x};
  assign raw_in[1] = '{f: fac_y, a: a_y, b: b_y};
  assign raw_in[2] = '{f: fac_z, a: a_z, b: b_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      va        <= &dv;
      vb        <= va;
      vc        <= vb;
      out_valid <= vc;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    pbm_raw_t              raw1, raw2, raw3, raw4, raw5, raw_d;
    logic [CW-1:0]         ca2, cb2, ca3, cb3, ca4, cb4, ca5, cb5, ca_d, cb_d;
    logic [2*CW-1:0]       mab3, msc3, maa3;
    logic [CW-1:0]         ab4, sc4;
    logic [CW:0]           ab2_4, sc2_4;
    logic signed [2*SW-1:0] sl4;
    logic signed [SW-1:0]  onem2b, aa_s;
    logic signed [RW-1:0]  ea, eb, eab, eab2, esc, esc2, esl, one_r, rnd_c, rnd5, rnd_d;
    logic [NW-1:0]         num_c, num5, qd;
    logic [CW-1:0]         den_c, den5;
    logic [SIDEW-1:0]      sd;
    logic signed [31:0]    br, la_c, lb_c, lf_c, la_r, lb_r, lf_r, lr, l_c;
    logic signed [32:0]    om;
    logic signed [64:0]    p1, p2;
    logic signed [65:0]    sum, shs;

    assign onem2b = $signed(SW'(ONE_C)) - $signed(SW'({cb3, 1'b0}));
    assign aa_s   = $signed(SW'(CW'(maa3 >> FRAC_BITS)));

    assign ea    = $signed(RW'(ca4));
    assign eb    = $signed(RW'(cb4));
    assign eab   = $signed(RW'(ab4));
    assign eab2  = $signed(RW'(ab2_4));
    assign esc   = $signed(RW'(sc4));
    assign esc2  = $signed(RW'(sc2_4));
    assign esl   = $signed(RW'(sl4 >>> FRAC_BITS));
    assign one_r = $signed(RW'(ONE_C));

    always_comb begin
      case (cfg.blend_mode)
        MODE_MIX:        rnd_c = eb;
        MODE_DARKEN:     rnd_c = (ea < eb) ? ea : eb;
        MODE_MULTIPLY:   rnd_c = eab;
        MODE_LIGHTEN:    rnd_c = (ea > eb) ? ea : eb;
        MODE_SCREEN:     rnd_c = one_r - esc;
        MODE_OVERLAY:    rnd_c = (ca4 < HALF_C) ? eab2 : one_r - esc2;
        MODE_ADD:        rnd_c = ea + eb;
        MODE_SOFTLIGHT:  rnd_c = esl + eab2;
        MODE_LINEAR:     rnd_c = ea + (eb <<< 1) - one_r;
        MODE_DIFFERENCE: rnd_c = (ea > eb) ? ea - eb : eb - ea;
        MODE_EXCLUSION:  rnd_c = ea + eb - eab2;
        MODE_SUBTRACT:   rnd_c = ea - eb;
        default:         rnd_c = ea;
      endcase
      if (cfg.blend_mode == MODE_BURN) begin
        num_c = NW'(ONE_C - ca4) << FRAC_BITS;
      end else begin
        num_c = NW'(ca4) << FRAC_BITS;
      end
      den_c = (cfg.blend_mode == MODE_DODGE) ? ONE_C - cb4 : cb4;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        raw1  <= raw_in[l];
        raw2  <= raw1;
        ca2   <= clip_c(raw1.a);
        cb2   <= clip_c(raw1.b);
        raw3  <= raw2;
        ca3   <= ca2;
        cb3   <= cb2;
        mab3  <= ca2 * cb2;
        msc3  <= (ONE_C - ca2) * (ONE_C - cb2);
        maa3  <= ca2 * ca2;
        raw4  <= raw3;
        ca4   <= ca3;
        cb4   <= cb3;
        ab4   <= CW'(mab3 >> FRAC_BITS);
        ab2_4 <= (CW + 1)'({mab3, 1'b0} >> FRAC_BITS);
        sc4   <= CW'(msc3 >> FRAC_BITS);
        sc2_4 <= (CW + 1)'({msc3, 1'b0} >> FRAC_BITS);
        sl4   <= onem2b * aa_s;
        raw5  <= raw4;
        ca5   <= ca4;
        cb5   <= cb4;
        rnd5  <= rnd_c;
        num5  <= num_c;
        den5  <= den_c;
      end
    end

    pbm_div #(
      .NUM_W  (NW),
      .DEN_W  (CW),
      .SIDE_W (SIDEW)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v5),
      .num       (num5),
      .den       (den5),
      .side_in   ({rnd5, ca5, cb5, raw5}),
      .out_valid (dv[l]),
      .quo       (qd),
      .side_out  (sd)
    );

    assign rnd_d  = $signed(sd[SIDEW-1 -: RW]);
    assign ca_d   = sd[96+2*CW-1 -: CW];
    assign cb_d   = sd[96+CW-1 -: CW];
    assign raw_d  = sd[95:0];
    assign f_d[l] = raw_d.f;

    always_comb begin
      case (cfg.blend_mode)
        MODE_BURN: begin
          if (cb_d == '0 || qd > NW'(ONE_C)) begin
            br = '0;
          end else begin
            br = $signed(32'(ONE_C - qd[CW-1:0]));
          end
        end
        MODE_DODGE: begin
          if (cb_d == ONE_C || qd > NW'(ONE_C)) begin
            br = ONE_S;
          end else begin
            br = $signed(32'(qd[CW-1:0]));
          end
        end
        MODE_DIVIDE: begin
          if (cb_d == '0) begin
            br = '0;
          end else if (64'(qd) > 64'h7fff_ffff) begin
            br = 32'sh7fff_ffff;
          end else begin
            br = $signed(32'(qd));
          end
        end
        default: br = 32'(rnd_d);
      endcase
      case (cfg.data_kind)
        KIND_COLOR: begin
          la_c = $signed(32'(ca_d));
          lb_c = br;
          lf_c = f_d[0];
        end
        KIND_VECTOR: begin
          la_c = raw_d.a;
          lb_c = raw_d.b;
          lf_c = cfg.per_lane_factor ? raw_d.f : f_d[0];
        end
        default: begin
          la_c = raw_d.a;
          lb_c = raw_d.b;
          lf_c = f_d[0];
        end
      endcase
    end

    assign om  = $signed({ONE_S[31], ONE_S}) - $signed({lf_r[31], lf_r});
    assign sum = $signed({p1[64], p1}) + $signed({p2[64], p2});
    assign shs = sum >>> FRAC_BITS;

    always_comb begin
      if (shs > MAX_W) begin
        l_c = 32'sh7fff_ffff;
      end else if (shs < MIN_W) begin
        l_c = 32'sh8000_0000;
      end else begin
        l_c = shs[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        la_r <= la_c;
        lb_r <= lb_c;
        lf_r <= lf_c;
        p1   <= la_r * om;
        p2   <= lb_r * lf_r;
        lr   <= l_c;
        case (cfg.data_kind)
          KIND_SCALAR: begin
            if (l == 0) begin
              res[l] <= cfg.clamp_enable ? clip_s(lr) : lr;
            end else begin
              res[l] <= '0;
            end
          end
          KIND_VECTOR: res[l] <= lr;
          KIND_COLOR:  res[l] <= clip_s(lr);
          default:     res[l] <= '0;
        endcase
      end
    end
  end

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];

endmodule

>>> rtl/pbm_checker.sv
// pbm_checker: port-level checks of the pixel blend mix unit, bound to the top level
module pbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z
);

  // held word keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("stalled output word changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // input only backs up behind a held output word
  a_stall: assert property (@(posedge clk) in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output word");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_stall |-> !in_stall)
    else $error("input stalled while output free");

endmodule

bind pixel_blend_mix_unit pbm_checker u_pbm_checker (.*);

>>> verif/testbench.sv
// testbench: self-checking testbench for the pixel blend mix unit, predicted results per word
module testbench import pbm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = PBM_FRAC_BITS;
  localparam longint ONE = longint'(1) << FB;
  localparam longint HALF = ONE >> 1;
  localparam int LATENCY = 2 * FB + 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] fac_x = '0, fac_y = '0, fac_z = '0;
  logic signed [31:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [31:0] b_x = '0, b_y = '0, b_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pixel_t;

  pbm_cfg_t cfg;
  pixel_t pending_pixels[$];
  int errors = 0;
  bit hold_off = 1'b0;
  bit bursty = 1'b1;

  pixel_blend_mix_unit u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  function automatic longint fshr(longint v);
    return v >>> FB;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip01(longint v);
    if (v < 0) return 0;
    if (v > ONE) return ONE;
    return v;
  endfunction

  function automatic longint lerp_sat(longint a, longint b, longint f);
    longint p1, p2, lo;
    p1 = a * (ONE - f);
    p2 = b * f;
    lo = (p1 & (ONE - 1)) + (p2 & (ONE - 1));
    return sat32(fshr(p1) + fshr(p2) + (lo >>> FB));
  endfunction

  function automatic longint fmul(longint x, longint y);
    return fshr(x * y);
  endfunction

  function automatic longint blend_chan(longint a, longint b);
    longint r;
    case (cfg.blend_mode)
      MODE_MIX: r = b;
      MODE_DARKEN: r = a < b ? a : b;
      MODE_MULTIPLY: r = fmul(a, b);
      MODE_BURN: begin
        if (b == 0) r = 0;
        else begin
          r = ONE - (((ONE - a) << FB) / b);
          if (r < 0) r = 0;
        end
      end
      MODE_LIGHTEN: r = a > b ? a : b;
      MODE_SCREEN: r = ONE - fmul(ONE - a, ONE - b);
      MODE_DODGE: begin
        if (b == ONE) r = ONE;
        else begin
          r = (a << FB) / (ONE - b);
          if (r > ONE) r = ONE;
        end
      end
      MODE_OVERLAY: r = (a < HALF) ? fmul(2 * a, b) : ONE - fmul(2 * (ONE - a), ONE - b);
      MODE_ADD: r = a + b;
      MODE_SOFTLIGHT: r = fmul(ONE - 2 * b, fmul(a, a)) + fmul(2 * b, a);
      MODE_LINEAR: r = a + 2 * b - ONE;
      MODE_DIFFERENCE: r = a > b ? a - b : b - a;
      MODE_EXCLUSION: r = a + b - fmul(2 * a, b);
      MODE_SUBTRACT: r = a - b;
      MODE_DIVIDE: r = (b == 0) ? 0 : (a << FB) / b;
      default: r = a;
    endcase
    return sat32(r);
  endfunction

  function automatic pixel_t mix_pixel(logic signed [31:0] f[3], logic signed [31:0] a[3],
                                       logic signed [31:0] b[3]);
    longint r[3];
    longint ca, cb;
    pixel_t p;
    r = '{0, 0, 0};
    case (cfg.data_kind)
      KIND_SCALAR: begin
        r[0] = lerp_sat(a[0], b[0], f[0]);
        if (cfg.clamp_enable) r[0] = clip01(r[0]);
      end
      KIND_VECTOR: begin
        for (int i = 0; i < 3; i++)
          r[i] = lerp_sat(a[i], b[i], cfg.per_lane_factor ? f[i] : f[0]);
      end
      KIND_COLOR: begin
        for (int i = 0; i < 3; i++) begin
          ca = clip01(a[i]);
          cb = clip01(b[i]);
          r[i] = clip01(lerp_sat(ca, blend_chan(ca, cb), f[0]));
        end
      end
      default: ;
    endcase
    p.x = r[0][31:0];
    p.y = r[1][31:0];
    p.z = r[2][31:0];
    return p;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KIND: cfg.data_kind = value[1:0];
      REG_MODE: cfg.blend_mode = value[4:0];
      REG_LANE: cfg.per_lane_factor = value[0];
      default: cfg.clamp_enable = value[0];
    endcase
  endtask

  task automatic set_cfg(logic [1:0] kind, logic [4:0] mode, bit lane, bit clamp);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    write_reg(REG_KIND, kind);
    write_reg(REG_MODE, mode);
    write_reg(REG_LANE, lane);
    write_reg(REG_CLAMP, clamp);
  endtask

  // sends one word, waits for acceptance, then, when bursty, an occasional random gap
  task automatic send_word(logic signed [31:0] f[3], logic signed [31:0] a[3],
                           logic signed [31:0] b[3]);
    in_valid <= 1'b1;
    {fac_x, fac_y, fac_z} <= {f[0], f[1], f[2]};
    {a_x, a_y, a_z} <= {a[0], a[1], a[2]};
    {b_x, b_y, b_z} <= {b[0], b[1], b[2]};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pixels.push_back(mix_pixel(f, a, b));
    if (bursty && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick_val(bit unit_range);
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'(ONE);
      3: return 0;
      4: return 32'(HALF);
      5, 6: return $urandom();
      default: return unit_range ? $urandom_range(0, ONE) : $signed($urandom_range(0, 4 * ONE)) - 32'(2 * ONE);
    endcase
  endfunction

  task automatic send_random(int n, bit unit_range);
    logic signed [31:0] f[3], a[3], b[3];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        f[i] = pick_val(1'b1);
        a[i] = pick_val(unit_range);
        b[i] = pick_val(unit_range);
      end
      send_word(f, a, b);
    end
    in_valid <= 1'b0;
  endtask

  task automatic test_directed();
    logic signed [31:0] e[6];
    logic signed [31:0] f[3], a[3], b[3];
    e = '{32'sh7fffffff, 32'sh80000000, 0, 32'(ONE), 32'(HALF), -1};
    set_cfg(KIND_SCALAR, MODE_MIX, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) begin
      f = '{e[i], e[5 - i], e[i]};
      a = '{e[5 - i], e[i], e[5 - i]};
      b = '{e[(i + 2) % 6], e[(i + 3) % 6], e[(i + 4) % 6]};
      send_word(f, a, b);
    end
    in_valid <= 1'b0;
    // zero divisor and unit divisor cases for burn, dodge and divide
    for (int m = 0; m < 3; m++) begin
      set_cfg(KIND_COLOR, m == 0 ? MODE_BURN : (m == 1 ? MODE_DODGE : MODE_DIVIDE), 1'b0, 1'b1);
      f = '{32'(ONE), 0, 0};
      a = '{32'(HALF), 32'(ONE), 0};
      b = '{0, 32'(ONE), 1};
      send_word(f, a, b);
      a = '{32'(ONE), 1, 32'(HALF)};
      b = '{1, 32'(ONE) - 1, 2};
      send_word(f, a, b);
      in_valid <= 1'b0;
    end
    // unused kind gives zeros
    set_cfg(2'd3, MODE_MIX, 1'b1, 1'b1);
    send_random(4, 1'b0);
  endtask

  task automatic test_scalar();
    set_cfg(KIND_SCALAR, 5'd31, 1'b1, 1'b0);
    send_random(80, 1'b0);
    set_cfg(KIND_SCALAR, MODE_MIX, 1'b0, 1'b1);
    send_random(80, 1'b0);
  endtask

  task automatic test_vector();
    set_cfg(KIND_VECTOR, MODE_MIX, 1'b0, 1'b1);
    send_random(80, 1'b0);
    set_cfg(KIND_VECTOR, MODE_DIVIDE, 1'b1, 1'b0);
    send_random(80, 1'b0);
  endtask

  task automatic test_color_modes();
    for (int m = 0; m < 19; m++) begin
      set_cfg(KIND_COLOR, m[4:0], m[0], m[1]);
      send_random(32, m[2]);
    end
  endtask

  task automatic test_backpressure();
    set_cfg(KIND_COLOR, MODE_SOFTLIGHT, 1'b0, 1'b0);
    bursty = 1'b0;
    hold_off = 1'b1;
    send_random(80, 1'b1);
    bursty = 1'b1;
  endtask

  // receiver stall pattern; a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (LATENCY * 3) @(posedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  always @(posedge clk) begin
    pixel_t exp_pix;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t unexpected word: actual %h %h %h", $time, out_x, out_y, out_z);
      end else begin
        exp_pix = pending_pixels.pop_front();
        if (out_x !== exp_pix.x) begin
          errors++;
          $display("%0t out_x expected %h actual %h", $time, exp_pix.x, out_x);
        end
        if (out_y !== exp_pix.y) begin
          errors++;
          $display("%0t out_y expected %h actual %h", $time, exp_pix.y, out_y);
        end
        if (out_z !== exp_pix.z) begin
          errors++;
          $display("%0t out_z expected %h actual %h", $time, exp_pix.z, out_z);
        end
      end
    end
  end

  initial begin
    int wait_cycles;
    cfg = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_scalar();
    test_vector();
    test_color_modes();
    test_backpressure();
    wait_cycles = 0;
    while (pending_pixels.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pbm_pkg.sv
rtl/pbm_div.sv
rtl/pixel_blend_mix_unit.sv
rtl/pbm_checker.sv
verif/testbench.sv
